FILE: sv/sbid_pkg.sv
// Shared types, codes and the field decode function for the stop-bit integer decoder.
// No dependencies; used by stop_bit_integer_decoder and its port checker.
package sbid_pkg;

  localparam logic [1:0] KIND_U32 = 2'd0;
  localparam logic [1:0] KIND_U64 = 2'd1;
  localparam logic [1:0] KIND_I32 = 2'd2;
  localparam logic [1:0] KIND_I64 = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVF      = 2'd1;
  localparam logic [1:0] ST_NONCANON = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [3:0] LIM_SHORT = 4'd5;
  localparam logic [3:0] LIM_LONG  = 4'd10;

  localparam logic [63:0] MAX_I64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_I32 = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MAX_U32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] NUL_U32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] NUL_I32 = 64'h0000_0000_8000_0000;
  localparam logic [6:0]  GRP_ONES = 7'h7F;

  typedef struct packed {
    logic [63:0] value;
    logic        is_null;
    logic [1:0]  status;
  } res_t;

  // Decode a completed field: acc holds the low 64 bits of the groups, top the first group.
  function automatic res_t decode(logic [63:0] acc, logic [6:0] top, logic [3:0] n,
                                  logic [1:0] knd, logic nb);
    res_t        r;
    logic [5:0]  pm1;
    logic [6:0]  sh;
    logic [63:0] v;
    logic        brd;
    logic        uns_nc;
    logic        sgn_nc;
    logic        lng;
    r.value   = '0;
    r.is_null = 1'b0;
    r.status  = ST_OK;
    lng = (n == LIM_LONG);
    // top bit of the second group; only looked at when n > 1
    pm1 = 6'(7 * int'(n) - 8);
    sh  = 7'(7 * int'(n));
    brd = acc[pm1];
    uns_nc = (n > 4'd1) && (top == 7'd0);
    sgn_nc = (n > 4'd1) && (((top == 7'd0) && !brd) || ((top == GRP_ONES) && brd));
    v = top[6] ? (acc | ({64{1'b1}} << sh)) : acc;
    case (knd)
      KIND_U32: begin
        if (!nb) begin
          if (acc > MAX_U32) r.status = ST_OVF;
          else if (uns_nc) r.status = ST_NONCANON;
          else r.value = acc;
        end else begin
          if (uns_nc) r.status = ST_NONCANON;
          else if (acc == 64'd0) r.is_null = 1'b1;
          else if (acc > NUL_U32) r.status = ST_OVF;
          else r.value = acc - 64'd1;
        end
      end
      KIND_U64: begin
        if (!lng) begin
          if (uns_nc) r.status = ST_NONCANON;
          else if (nb && acc == 64'd0) r.is_null = 1'b1;
          else r.value = nb ? acc - 64'd1 : acc;
        end else if (!nb) begin
          if (top >= 7'd2) r.status = ST_OVF;
          else if (top == 7'd0) r.status = ST_NONCANON;
          else r.value = acc;
        end else begin
          if (top > 7'd2 || (top == 7'd2 && acc[62:0] != '0)) r.status = ST_OVF;
          else if (top == 7'd0) r.status = ST_NONCANON;
          else r.value = (top == 7'd1) ? MAX_I64 + {1'b0, acc[62:0]} : {64{1'b1}};
        end
      end
      KIND_I32: begin
        if (!nb) begin
          if (n == LIM_SHORT && !((&v[63:31]) || !(|v[63:31]))) r.status = ST_OVF;
          else if (sgn_nc) r.status = ST_NONCANON;
          else r.value = v;
        end else begin
          if (sgn_nc) r.status = ST_NONCANON;
          else if (v == 64'd0) r.is_null = 1'b1;
          else if (v[63]) begin
            if (v < MIN_I32) r.status = ST_OVF;
            else r.value = v;
          end else begin
            if (v > NUL_I32) r.status = ST_OVF;
            else r.value = v - 64'd1;
          end
        end
      end
      default: begin
        if (!lng) begin
          if (sgn_nc) r.status = ST_NONCANON;
          else if (nb && v == 64'd0) r.is_null = 1'b1;
          else r.value = (nb && !v[63]) ? v - 64'd1 : v;
        end else if (!nb) begin
          if (top != 7'd0 && top != GRP_ONES) r.status = ST_OVF;
          else if (acc[63] == acc[62]) r.status = ST_NONCANON;
          else r.value = acc;
        end else if (!top[6]) begin
          if (top > 7'd1 || (top == 7'd1 && acc[62:0] != '0)) r.status = ST_OVF;
          else if (top == 7'd0 && !acc[62]) r.status = ST_NONCANON;
          else r.value = (top == 7'd1) ? MAX_I64 : {1'b0, acc[62:0]} - 64'd1;
        end else begin
          if (top != GRP_ONES) r.status = ST_OVF;
          else if (acc[62]) r.status = ST_NONCANON;
          else r.value = {1'b1, acc[62:0]};
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: sv/stop_bit_integer_decoder.sv
// Stop-bit integer decoder: wire bytes in, each decoded field out as a result beat.
// Depends on sbid_pkg for kind and status codes and the field decode function.
//
// Takes one wire byte per cycle while input ready is high, with no gaps of its own. A
// byte is held in an input register; when it moves on, its group is shifted into the
// field accumulator and, on a stop byte or when the byte limit (5 for 32-bit kinds, 10
// for 64-bit) is reached, the field is decoded into the output register. Its last byte
// waits in the input register while an earlier result waits at the output. Kind and
// nullable are sampled with the first byte of each field. Input ready drops only while a
// result waits in the output register and the held byte would produce another one.
module stop_bit_integer_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  wire_byte,
  input  logic [1:0]  kind,
  input  logic        nullable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic        is_null,
  output logic [1:0]  status,
  output logic [3:0]  byte_count
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [1:0]  s1_kind;
  logic        s1_nullable;

  logic [63:0] accumulator;
  logic [6:0]  first_group;
  logic [3:0]  bytes_seen;
  logic [1:0]  field_kind;
  logic        field_nullable;

  logic        first;
  logic [63:0] accumulator_next;
  logic [6:0]  top;
  logic [1:0]  knd;
  logic        nb;
  logic [3:0]  n;
  logic [3:0]  lim;
  logic        emit;
  logic        s1_go;
  sbid_pkg::res_t dec;

  assign first = (bytes_seen == 4'd0);
  assign accumulator_next = {(first ? 64'd0 : accumulator) << 7} | {57'd0, s1_byte[6:0]};
  assign top  = first ? s1_byte[6:0] : first_group;
  assign knd  = first ? s1_kind : field_kind;
  assign nb   = first ? s1_nullable : field_nullable;
  assign n    = bytes_seen + 4'd1;
  assign lim  = knd[0] ? sbid_pkg::LIM_LONG : sbid_pkg::LIM_SHORT;
  assign emit = s1_byte[7] || (n == lim);

  // hold the byte while its result cannot enter the output register
  assign s1_go    = !(emit && out_valid && !out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_comb begin
    dec = sbid_pkg::decode(accumulator_next, top, n, knd, nb);
    if (!s1_byte[7]) begin
      dec.value   = '0;
      dec.is_null = 1'b0;
      dec.status  = sbid_pkg::ST_INVALID;
    end else if (dec.status != sbid_pkg::ST_OK) begin
      dec.value   = '0;
      dec.is_null = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte     <= wire_byte;
      s1_kind     <= kind;
      s1_nullable <= nullable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      first_group    <= '0;
      bytes_seen     <= '0;
      field_kind     <= '0;
      field_nullable <= 1'b0;
    end else if (s1_valid && s1_go) begin
      accumulator    <= accumulator_next;
      first_group    <= top;
      field_kind     <= knd;
      field_nullable <= nb;
      bytes_seen     <= emit ? 4'd0 : n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_valid && s1_go && emit) begin
      value      <= dec.value;
      is_null    <= dec.is_null;
      status     <= dec.status;
      byte_count <= n;
    end
  end

endmodule

FILE: sv/sbid_port_checker.sv
// Port-level checks on the stop-bit integer decoder's result channel.
// Depends on sbid_pkg for status codes; bound to stop_bit_integer_decoder below.
module sbid_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value,
  input logic        is_null,
  input logic [1:0]  status,
  input logic [3:0]  byte_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status)
      && $stable(is_null) && $stable(byte_count))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sbid_pkg::ST_OK |-> value == 64'd0 && !is_null)
    else $error("error result carries a value or null flag");

  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_null |-> value == 64'd0 && status == sbid_pkg::ST_OK)
    else $error("null result is not a clean zero");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count >= 4'd1 && byte_count <= 4'd10)
    else $error("byte count out of range");

  a_invalid_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sbid_pkg::ST_INVALID |-> byte_count == 4'd5 || byte_count == 4'd10)
    else $error("missing stop bit reported at the wrong length");

endmodule

bind stop_bit_integer_decoder sbid_port_checker u_sbid_port_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .value      (value),
  .is_null    (is_null),
  .status     (status),
  .byte_count (byte_count)
);
